// ===== rtl/core/swc_pkg.sv =====
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types and constants for the staircase ways counter.
// ----------------------------------------------------------------------------
package swc_pkg;

    localparam int NUM_STEP_REGS = 7;
    localparam int STEP_W        = 10;
    localparam int HEIGHT_W      = 10;
    localparam int COUNT_W       = 64;
    localparam int NSTEPS_W      = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_STEPS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FIRST = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LAST  = 4'd7;

    typedef logic [NUM_STEP_REGS-1:0][STEP_W-1:0] t_step_arr;

    // one table entry: saturated count plus sticky overflow
    typedef struct packed {
        logic               ovf;
        logic [COUNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic clr;
        logic add_one;
        logic add_mem;
    } t_acc_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_ADD,
        ST_WRITE,
        ST_RESP
    } t_state;

endpackage

// ===== rtl/core/swc_ram.sv =====
// ----------------------------------------------------------------------------
// swc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/swc_acc.sv =====
// ----------------------------------------------------------------------------
// swc_acc
// Shared 64-bit saturating accumulator with sticky overflow.
// ----------------------------------------------------------------------------
module swc_acc (
    input  logic                        i_clk,
    input  swc_pkg::t_acc_ctl           i_ctl,
    input  swc_pkg::t_entry             i_mem,
    output swc_pkg::t_entry             o_acc
);
    import swc_pkg::*;

    logic [COUNT_W-1:0] r_cnt;
    logic               r_ovf;
    logic [COUNT_W-1:0] n_cnt;
    logic               n_ovf;
    logic [COUNT_W-1:0] add_val;
    logic [COUNT_W:0]   sum;

    always_comb begin
        add_val = i_ctl.add_one ? COUNT_W'(1) : i_mem.cnt;
        sum     = {1'b0, r_cnt} + {1'b0, add_val};
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        if (i_ctl.clr) begin
            n_cnt = '0;
            n_ovf = 1'b0;
        end else if (i_ctl.add_one || i_ctl.add_mem) begin
            n_cnt = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
            n_ovf = r_ovf | sum[COUNT_W] | (i_ctl.add_mem & i_mem.ovf);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_ovf <= n_ovf;
    end

    assign o_acc.cnt = r_cnt;
    assign o_acc.ovf = r_ovf;

endmodule

// ===== rtl/core/swc_ctrl.sv =====
// ----------------------------------------------------------------------------
// swc_ctrl
// Sequencer: extends the ways table one height at a time, walking the step
// list per entry, then reads the requested entry out.
// ----------------------------------------------------------------------------
module swc_ctrl #(
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_STEPS  = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_clear,
    input  logic [swc_pkg::NSTEPS_W-1:0]      i_num_steps,
    input  swc_pkg::t_step_arr                i_step_size,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [swc_pkg::HEIGHT_W-1:0]      i_target_height,
    input  logic                              i_out_free,
    output logic                              o_out_load,
    output logic                              o_out_zero,
    output swc_pkg::t_acc_ctl                 o_acc_ctl,
    output logic                              o_rd_en,
    output logic [$clog2(MAX_HEIGHT)-1:0]     o_rd_addr,
    output logic                              o_wr_en,
    output logic [$clog2(MAX_HEIGHT)-1:0]     o_wr_addr
);
    import swc_pkg::*;

    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int FW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = ((FW > HEIGHT_W) ? FW : HEIGHT_W) + 1;

    t_state                r_state;
    t_state                n_state;
    logic [HEIGHT_W-1:0]   r_n;
    logic [FW-1:0]         r_filled;
    logic [NSTEPS_W-1:0]   r_idx;
    logic                  r_zero;

    logic [NSTEPS_W-1:0]   cnt_clip;
    logic [STEP_W-1:0]     step;
    logic [CW-1:0]         n_ext;
    logic [CW-1:0]         h_ext;
    logic [CW-1:0]         s_ext;
    logic [CW-1:0]         diff;
    logic                  out_range;
    logic                  have;
    logic                  idx_done;
    logic                  s_skip;
    logic                  s_hit;

    always_comb begin
        cnt_clip  = (i_num_steps > NSTEPS_W'(MAX_STEPS)) ? NSTEPS_W'(MAX_STEPS)
                                                         : i_num_steps;
        step      = i_step_size[r_idx];
        n_ext     = CW'(r_n);
        h_ext     = CW'(r_filled);   // entry under construction
        s_ext     = CW'(step);
        diff      = h_ext - s_ext;
        out_range = n_ext >= CW'(MAX_HEIGHT);
        have      = h_ext > n_ext;
        idx_done  = r_idx >= cnt_clip;
        s_skip    = (step == '0) || (s_ext > h_ext);
        s_hit     = s_ext == h_ext;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = (out_range || have) ? ST_RESP : ST_STEP;
            end
            ST_STEP: begin
                if (idx_done) begin
                    n_state = ST_WRITE;
                end else if (!s_skip && !s_hit) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD:   n_state = ST_STEP;
            ST_WRITE: n_state = ST_CHECK;
            ST_RESP: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_acc_ctl  = '0;
        o_rd_en    = 1'b0;
        o_rd_addr  = n_ext[AW-1:0];
        o_wr_en    = 1'b0;
        o_wr_addr  = h_ext[AW-1:0];
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_CHECK: begin
                o_rd_en       = have && !out_range;
                o_acc_ctl.clr = !(have || out_range);
            end
            ST_STEP: begin
                if (!idx_done && s_hit) begin
                    o_acc_ctl.add_one = 1'b1;
                end else if (!idx_done && !s_skip) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = diff[AW-1:0];
                end
            end
            ST_ADD:   o_acc_ctl.add_mem = 1'b1;
            ST_WRITE: o_wr_en = 1'b1;
            ST_RESP:  o_out_load = i_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_filled <= '0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_clear) begin
                r_filled <= '0;
            end else if (r_state == ST_WRITE) begin
                r_filled <= r_filled + FW'(1);
            end
            if (r_state == ST_CHECK) begin
                r_idx <= '0;
            end else if ((r_state == ST_ADD) ||
                         (r_state == ST_STEP && !idx_done && (s_skip || s_hit))) begin
                r_idx <= r_idx + NSTEPS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_n <= i_target_height;
        end
        if (r_state == ST_CHECK) begin
            r_zero <= out_range;
        end
    end

    assign o_out_zero = r_zero;

endmodule

// ===== rtl/core/staircase_ways_counter_top.sv =====
// ----------------------------------------------------------------------------
// staircase_ways_counter_top
// Counts ordered sequences of configured step sizes that sum to a height.
// ----------------------------------------------------------------------------
// A request for height n is answered from a table of counts that the block
// keeps for heights 0 up to a high-water mark. A height already in the table
// is read in the check state and loaded into the output register once it is
// free; the block then takes the next item. Otherwise the table is extended
// one height at a time through a single saturating 64-bit adder: each new
// entry passes through the check state, the step states and an add state
// for each step size that reads an earlier entry (none for a step that is
// skipped or lands exactly), then the write state; the single read port and
// the one adder set this pace. A write to the step count or to a step size
// register empties the table, so the next item refills it. Input is not
// taken while an item is in progress; a finished result sits in an output
// register until taken. Heights of MAX_HEIGHT or more answer zero.
// ----------------------------------------------------------------------------
module staircase_ways_counter_top #(
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_STEPS  = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [swc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [swc_pkg::HEIGHT_W-1:0]      i_target_height,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [swc_pkg::COUNT_W-1:0]       o_way_count,
    output logic                              o_overflow
);
    import swc_pkg::*;

    localparam int AW = $clog2(MAX_HEIGHT);

    logic [NSTEPS_W-1:0]  r_num_steps;
    t_step_arr            r_step_size;
    logic                 cfg_clear;
    logic [CFG_IDX_W-1:0] step_sel;

    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_way_count;
    logic                 r_overflow;
    logic                 out_free;
    logic                 out_load;
    logic                 out_zero;

    t_acc_ctl             acc_ctl;
    t_entry               acc_q;
    t_entry               rd_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;

    // configuration registers
    assign step_sel  = i_cfg_idx - REG_STEP_FIRST;
    assign cfg_clear = i_cfg_we && (i_cfg_idx <= REG_STEP_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_steps <= '0;
            for (int k = 0; k < NUM_STEP_REGS; k++) begin
                r_step_size[k] <= STEP_W'(1);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NUM_STEPS) begin
                r_num_steps <= i_cfg_data[NSTEPS_W-1:0];
            end else if (i_cfg_idx inside {[REG_STEP_FIRST:REG_STEP_LAST]}) begin
                r_step_size[step_sel[NSTEPS_W-1:0]] <= i_cfg_data[STEP_W-1:0];
            end
        end
    end

    swc_ctrl #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_STEPS  (MAX_STEPS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_clear     (cfg_clear),
        .i_num_steps     (r_num_steps),
        .i_step_size     (r_step_size),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_target_height (i_target_height),
        .i_out_free      (out_free),
        .o_out_load      (out_load),
        .o_out_zero      (out_zero),
        .o_acc_ctl       (acc_ctl),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr)
    );

    swc_acc u_acc (
        .i_clk (i_clk),
        .i_ctl (acc_ctl),
        .i_mem (rd_data),
        .o_acc (acc_q)
    );

    swc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_HEIGHT)
    ) u_ways_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (acc_q),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_way_count <= out_zero ? '0 : rd_data.cnt;
            r_overflow  <= out_zero ? 1'b0 : rd_data.ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_way_count = r_way_count;
    assign o_overflow  = r_overflow;

`ifndef SYNTH
    // table port is never read and written in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("ways table read and write in the same cycle");

    // the table is only extended while an item is in progress
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !wr_en)
        else $error("ways table written while idle");

    // a result never overwrites one that has not been taken
    a_no_result_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // a flagged overflow always comes with a saturated count
    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_overflow) |-> (r_way_count == '1))
        else $error("overflow flagged without saturated count");
`endif

endmodule
